[rtl/gphs_pkg.sv]
// gphs_pkg: shared types and constants for the grid point height statistics block
// holds the sequencer state type, the cell record layout and the divider sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gphs_pkg;

    // shared divider operand widths
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 16;

    localparam int HECTARE_M2 = 100 * 100;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_EAST  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_NORTH = 3'd1;
    localparam logic [2:0] CFG_CELL_SIZE    = 3'd2;
    localparam logic [2:0] CFG_GRID_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_GRID_LENGTH  = 3'd4;

    typedef enum logic [17:0] {
        ST_CLEAR      = 18'h00001,
        ST_IDLE       = 18'h00002,
        ST_COL_GO     = 18'h00004,
        ST_COL_WAIT   = 18'h00008,
        ST_ROW_GO     = 18'h00010,
        ST_ROW_WAIT   = 18'h00020,
        ST_ADD_RD     = 18'h00040,
        ST_ADD_WR     = 18'h00080,
        ST_CELL_RD    = 18'h00100,
        ST_CELL_LOAD  = 18'h00200,
        ST_RATIO_GO   = 18'h00400,
        ST_RATIO_WAIT = 18'h00800,
        ST_MEAN_GO    = 18'h01000,
        ST_MEAN_WAIT  = 18'h02000,
        ST_VAR_GO     = 18'h04000,
        ST_VAR_WAIT   = 18'h08000,
        ST_DENS       = 18'h10000,
        ST_OUT        = 18'h20000
    } state_t;

    // one grid cell as kept in the cell memory
    typedef struct packed {
        logic        [15:0] count;
        logic        [7:0]  kept;
        logic signed [31:0] sum;
        logic        [53:0] sq_sum;
        logic signed [23:0] min_h;
        logic signed [23:0] max_h;
    } entry_t;

endpackage

`default_nettype wire

[rtl/gphs_ram.sv]
// gphs_ram: generic single write port memory with one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                   aclk,
    input  wire                                   wr_en,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                      wr_data,
    input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/gphs_div.sv]
// gphs_div: shared restoring divider, one quotient bit per cycle
// depends on gphs_pkg for the operand widths
`timescale 1ns / 1ps
`default_nettype none

module gphs_div (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            start,
    input  wire  [gphs_pkg::DIV_NUM_W-1:0] dividend,
    input  wire  [gphs_pkg::DIV_DEN_W-1:0] divisor,
    output logic                           busy,
    output logic                           done,
    output logic [gphs_pkg::DIV_NUM_W-1:0] quotient
);

    localparam int NW = gphs_pkg::DIV_NUM_W;
    localparam int DW = gphs_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(NW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/grid_point_height_statistics.sv]
// grid_point_height_statistics: bins points into grid cells and reads back cell statistics
// depends on gphs_pkg, gphs_div and gphs_ram
// an add item runs up to two divider passes (column, then row) before its result, a read item up
// to the ratio, mean and variance divisions; an outside read or an add with zero cell size
// goes straight to the output state
// one item at a time: the next item is taken in the cycle after the result is loaded
// after reset a clearing pass zeroes the cell memory, s_tready stays low until it ends;
// configuration writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module grid_point_height_statistics #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int MAX_KEPT    = 255
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [119:0] s_tdata,   // east, north, elevation, read_row, read_col
    input  wire  [0:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [167:0] m_tdata,   // tree_count, density, min, max, mean, variance, zero pad
    output logic [0:0]   m_tuser,   // status
    input  wire          cfg_wr_en,
    input  wire  [2:0]   cfg_index,
    input  wire  [39:0]  cfg_wdata
);

    localparam int CELLS  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = CELLS > 1 ? $clog2(CELLS) : 1;
    localparam int EW     = $bits(gphs_pkg::entry_t);
    localparam int NW     = gphs_pkg::DIV_NUM_W;
    localparam int DW     = gphs_pkg::DIV_DEN_W;

    // configuration
    logic signed [39:0] origin_east_reg;
    logic signed [39:0] origin_north_reg;
    logic [7:0]         cell_size_reg;
    logic [8:0]         grid_width_reg;
    logic [8:0]         grid_length_reg;

    gphs_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              m_tvalid_reg;

    // item payload
    logic                s_func;
    logic signed [39:0]  s_east;
    logic signed [39:0]  s_north;
    logic signed [23:0]  s_elev;
    logic [7:0]          s_row;
    logic [7:0]          s_col;

    logic signed [40:0]  dx;
    logic signed [40:0]  dy;
    logic [23:0]         zmag;
    logic [12:0]         used_cols;
    logic [12:0]         used_rows;
    logic [7:0]          kept_limit;
    logic [15:0]         csq;
    logic                add_outside;
    logic                rd_outside;

    logic signed [23:0]  z_reg;
    logic [47:0]         zsq_reg;
    logic [31:0]         xs_reg;
    logic [31:0]         ys_reg;
    logic [12:0]         col_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                status_reg;
    gphs_pkg::entry_t    ent_reg;
    logic [31:0]         sm_reg;
    logic [63:0]         sq_reg;
    logic [63:0]         nq_reg;
    logic [15:0]         nn_reg;
    logic [13:0]         ratio_reg;
    logic signed [23:0]  mean_reg;
    logic [45:0]         var_reg;
    logic [29:0]         dens_reg;
    logic [167:0]        m_tdata_reg;
    logic                m_tuser_reg;

    // divider and memory
    logic                div_start;
    logic [NW-1:0]       div_num;
    logic [DW-1:0]       div_den;
    logic                div_busy;
    logic                div_done;
    logic [NW-1:0]       div_quo;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [EW-1:0]       ram_rdata;
    gphs_pkg::entry_t    rd_ent;
    gphs_pkg::entry_t    upd_ent;
    logic [63:0]         var_num;
    logic                out_load;

    function automatic logic [ADDR_W-1:0] cell_index(input logic [12:0] row,
                                                     input logic [12:0] col);
        logic [25:0] full;
        full = 26'(row) * 26'(MAX_COLUMNS) + 26'(col);
        return full[ADDR_W-1:0];
    endfunction

    assign s_east  = s_tdata[39:0];
    assign s_north = s_tdata[79:40];
    assign s_elev  = s_tdata[103:80];
    assign s_row   = s_tdata[111:104];
    assign s_col   = s_tdata[119:112];
    assign s_func  = s_tuser[0];

    assign dx = 41'(s_east) - 41'(origin_east_reg);
    assign dy = 41'(origin_north_reg) - 41'(s_north);
    assign zmag = s_elev[23] ? 24'(-s_elev) : s_elev;

    assign used_cols  = (13'(grid_width_reg) > 13'(MAX_COLUMNS)) ? 13'(MAX_COLUMNS)
                                                                 : 13'(grid_width_reg);
    assign used_rows  = (13'(grid_length_reg) > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
                                                               : 13'(grid_length_reg);
    assign kept_limit = (cell_size_reg < 8'(MAX_KEPT)) ? cell_size_reg : 8'(MAX_KEPT);
    assign csq        = 16'(cell_size_reg) * 16'(cell_size_reg);

    // floor of a negative difference lands left of or above the grid
    assign add_outside = (cell_size_reg == 8'd0) || dx[40] || dy[40];
    assign rd_outside  = (13'(s_row) >= used_rows) || (13'(s_col) >= used_cols);

    assign rd_ent  = gphs_pkg::entry_t'(ram_rdata);
    assign var_num = (nq_reg >= sq_reg) ? (nq_reg - sq_reg) : 64'd0;

    // read-modify-write of one cell for an add item
    always_comb begin
        upd_ent = rd_ent;
        if (rd_ent.count == 16'd0) begin
            upd_ent.min_h = z_reg;
            upd_ent.max_h = z_reg;
        end else begin
            if (z_reg < rd_ent.min_h) upd_ent.min_h = z_reg;
            if (z_reg > rd_ent.max_h) upd_ent.max_h = z_reg;
        end
        if (rd_ent.count != 16'hFFFF) upd_ent.count = rd_ent.count + 16'd1;
        if (rd_ent.kept < kept_limit) begin
            upd_ent.sum    = rd_ent.sum + 32'(z_reg);
            upd_ent.sq_sum = rd_ent.sq_sum + 54'(zsq_reg);
            upd_ent.kept   = rd_ent.kept + 8'd1;
        end
    end

    assign out_load = (state_reg == gphs_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = upd_ent;
        case (state_reg)
            gphs_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == ADDR_W'(CELLS - 1)) state_next = gphs_pkg::ST_IDLE;
            end
            gphs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_func) begin
                        state_next = rd_outside ? gphs_pkg::ST_OUT : gphs_pkg::ST_CELL_RD;
                    end else begin
                        state_next = add_outside ? gphs_pkg::ST_OUT : gphs_pkg::ST_COL_GO;
                    end
                end
            end
            gphs_pkg::ST_COL_GO: begin
                div_start  = 1'b1;
                div_num    = NW'(xs_reg);
                div_den    = DW'(cell_size_reg);
                state_next = gphs_pkg::ST_COL_WAIT;
            end
            gphs_pkg::ST_COL_WAIT: begin
                if (div_done) begin
                    state_next = (div_quo >= NW'(used_cols)) ? gphs_pkg::ST_OUT
                                                             : gphs_pkg::ST_ROW_GO;
                end
            end
            gphs_pkg::ST_ROW_GO: begin
                div_start  = 1'b1;
                div_num    = NW'(ys_reg);
                div_den    = DW'(cell_size_reg);
                state_next = gphs_pkg::ST_ROW_WAIT;
            end
            gphs_pkg::ST_ROW_WAIT: begin
                if (div_done) begin
                    state_next = (div_quo >= NW'(used_rows)) ? gphs_pkg::ST_OUT
                                                             : gphs_pkg::ST_ADD_RD;
                end
            end
            gphs_pkg::ST_ADD_RD: state_next = gphs_pkg::ST_ADD_WR;
            gphs_pkg::ST_ADD_WR: begin
                ram_we     = 1'b1;
                state_next = gphs_pkg::ST_OUT;
            end
            gphs_pkg::ST_CELL_RD: state_next = gphs_pkg::ST_CELL_LOAD;
            gphs_pkg::ST_CELL_LOAD: begin
                if (cell_size_reg != 8'd0) begin
                    state_next = gphs_pkg::ST_RATIO_GO;
                end else begin
                    state_next = (rd_ent.kept != 8'd0) ? gphs_pkg::ST_MEAN_GO
                                                       : gphs_pkg::ST_DENS;
                end
            end
            gphs_pkg::ST_RATIO_GO: begin
                div_start  = 1'b1;
                div_num    = NW'(gphs_pkg::HECTARE_M2);
                div_den    = csq;
                state_next = gphs_pkg::ST_RATIO_WAIT;
            end
            gphs_pkg::ST_RATIO_WAIT: begin
                if (div_done) begin
                    state_next = (ent_reg.kept != 8'd0) ? gphs_pkg::ST_MEAN_GO
                                                        : gphs_pkg::ST_DENS;
                end
            end
            gphs_pkg::ST_MEAN_GO: begin
                div_start  = 1'b1;
                div_num    = NW'(sm_reg) + NW'(ent_reg.kept[7:1]);
                div_den    = DW'(ent_reg.kept);
                state_next = gphs_pkg::ST_MEAN_WAIT;
            end
            gphs_pkg::ST_MEAN_WAIT: begin
                if (div_done) state_next = gphs_pkg::ST_VAR_GO;
            end
            gphs_pkg::ST_VAR_GO: begin
                div_start  = 1'b1;
                div_num    = var_num + NW'(nn_reg[15:1]);
                div_den    = nn_reg;
                state_next = gphs_pkg::ST_VAR_WAIT;
            end
            gphs_pkg::ST_VAR_WAIT: begin
                if (div_done) state_next = gphs_pkg::ST_DENS;
            end
            gphs_pkg::ST_DENS: state_next = gphs_pkg::ST_OUT;
            gphs_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) state_next = gphs_pkg::ST_IDLE;
            end
            default: state_next = gphs_pkg::ST_IDLE;
        endcase
    end

    // control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= gphs_pkg::ST_CLEAR;
            clr_addr_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
            origin_east_reg  <= '0;
            origin_north_reg <= '0;
            cell_size_reg    <= 8'd1;
            grid_width_reg   <= 9'd256;
            grid_length_reg  <= 9'd256;
        end else begin
            state_reg <= state_next;
            if (state_reg == gphs_pkg::ST_CLEAR) clr_addr_reg <= clr_addr_reg + 1'b1;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    gphs_pkg::CFG_ORIGIN_EAST:  origin_east_reg  <= cfg_wdata;
                    gphs_pkg::CFG_ORIGIN_NORTH: origin_north_reg <= cfg_wdata;
                    gphs_pkg::CFG_CELL_SIZE:    cell_size_reg    <= cfg_wdata[7:0];
                    gphs_pkg::CFG_GRID_WIDTH:   grid_width_reg   <= cfg_wdata[8:0];
                    gphs_pkg::CFG_GRID_LENGTH:  grid_length_reg  <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            gphs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    status_reg <= s_func ? rd_outside : add_outside;
                    z_reg      <= s_elev;
                    zsq_reg    <= 48'(zmag) * 48'(zmag);
                    xs_reg     <= dx[39:8];
                    ys_reg     <= dy[39:8];
                    addr_reg   <= cell_index(13'(s_row), 13'(s_col));
                    ent_reg    <= '0;
                    ratio_reg  <= '0;
                    mean_reg   <= '0;
                    var_reg    <= '0;
                    dens_reg   <= '0;
                end
            end
            gphs_pkg::ST_COL_WAIT: begin
                if (div_done) begin
                    col_reg <= div_quo[12:0];
                    if (div_quo >= NW'(used_cols)) status_reg <= 1'b1;
                end
            end
            gphs_pkg::ST_ROW_WAIT: begin
                if (div_done) begin
                    addr_reg <= cell_index(div_quo[12:0], col_reg);
                    if (div_quo >= NW'(used_rows)) status_reg <= 1'b1;
                end
            end
            gphs_pkg::ST_CELL_LOAD: begin
                ent_reg <= rd_ent;
                sm_reg  <= rd_ent.sum[31] ? 32'(-rd_ent.sum) : 32'(rd_ent.sum);
                sq_reg  <= (rd_ent.sum[31] ? 64'(32'(-rd_ent.sum)) : 64'(32'(rd_ent.sum)))
                         * (rd_ent.sum[31] ? 64'(32'(-rd_ent.sum)) : 64'(32'(rd_ent.sum)));
                nq_reg  <= 64'(rd_ent.kept) * 64'(rd_ent.sq_sum);
                nn_reg  <= 16'(rd_ent.kept) * 16'(rd_ent.kept);
            end
            gphs_pkg::ST_RATIO_WAIT: begin
                if (div_done) ratio_reg <= div_quo[13:0];
            end
            gphs_pkg::ST_MEAN_WAIT: begin
                // rounded magnitude takes the sign of the sum
                if (div_done) mean_reg <= ent_reg.sum[31] ? 24'(-div_quo) : 24'(div_quo);
            end
            gphs_pkg::ST_VAR_WAIT: begin
                if (div_done) var_reg <= div_quo[45:0];
            end
            gphs_pkg::ST_DENS: begin
                dens_reg <= 30'(32'(ent_reg.count) * 32'(ratio_reg));
            end
            gphs_pkg::ST_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= {4'd0, var_reg, mean_reg, ent_reg.max_h, ent_reg.min_h,
                                    dens_reg, ent_reg.count};
                    m_tuser_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    gphs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    gphs_ram #(
        .WIDTH (EW),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (addr_reg),
        .rd_data (ram_rdata)
    );

    assign s_tready = (state_reg == gphs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // no new transaction while the divider is still working
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("input accepted while divider busy");

    // the cell memory is written only by the clearing pass or an add update
    a_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == gphs_pkg::ST_CLEAR || state_reg == gphs_pkg::ST_ADD_WR))
        else $error("unexpected cell memory write");

    // a result appears only from the output state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == gphs_pkg::ST_OUT))
        else $error("result valid without output state");

    // divider completion only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == gphs_pkg::ST_COL_WAIT || state_reg == gphs_pkg::ST_ROW_WAIT
                   || state_reg == gphs_pkg::ST_RATIO_WAIT
                   || state_reg == gphs_pkg::ST_MEAN_WAIT
                   || state_reg == gphs_pkg::ST_VAR_WAIT))
        else $error("divider done outside a wait state");

endmodule

`default_nettype wire
